// ===== src/lzwd_pkg.sv =====
// Shared types and constants for the windowed LZSS decoder.
// Used by the front parser, the step queue, the copy engine and the top level.
package lzwd_pkg;

   localparam int WIN_AW    = 12;
   localparam int WIN_DEPTH = 4096;
   localparam int MAX_OPS   = 4;

   localparam logic [31:0] MAGIC_WORD  = 32'h56781234;
   localparam logic [11:0] START_EXT   = 12'h111;
   localparam logic [11:0] START_PLAIN = 12'hFEE;
   localparam logic [7:0]  FILL_BYTE   = 8'h20;
   localparam logic [7:0]  GROUP_TAG   = 8'hFF;

   // Parse phases.
   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_TAG    = 3'd1;
   localparam logic [2:0] PH_LIT    = 3'd2;
   localparam logic [2:0] PH_MA     = 3'd3;
   localparam logic [2:0] PH_MB     = 3'd4;
   localparam logic [2:0] PH_MC     = 3'd5;
   localparam logic [2:0] PH_GROUP  = 3'd6;

   // Stream status codes.
   localparam logic [1:0] ST_RUN      = 2'd0;
   localparam logic [1:0] ST_COUNT    = 2'd1;
   localparam logic [1:0] ST_CAPACITY = 2'd2;
   localparam logic [1:0] ST_ENDED    = 2'd3;

   // Copy operation kinds.
   localparam logic [1:0] OP_LIT   = 2'd0;
   localparam logic [1:0] OP_MATCH = 2'd1;
   localparam logic [1:0] OP_GROUP = 2'd2;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [63:0] out_data;
      logic [3:0]  out_count;
      logic        out_last;
      logic [1:0]  run_status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] val;
      logic [8:0]  len;
   } op_type;

   // Everything the copy engine needs to carry out one input byte.
   typedef struct packed {
      op_type [MAX_OPS-1:0] ops;
      logic [2:0]           nops;
      logic [63:0]          grp;
      logic [1:0]           status;
      logic                 stop;
      logic                 last;
      logic                 set_start;
      logic [11:0]          start;
   } step_type;

endpackage

// ===== src/lzwd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rd_ff;

endmodule

// ===== src/lzwd_front.sv =====
// Front parser: takes compressed bytes, tracks header, tags and counts, and
// turns the bytes into step records of copy operations. Uses lzwd_pkg.
module lzwd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic [23:0]       csr_cap,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzwd_pkg::req_type req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output lzwd_pkg::step_type push_data
);
   import lzwd_pkg::*;

   typedef struct packed {
      logic [31:0] rem;
      logic [23:0] wr;
      logic [7:0]  tag;
      logic [3:0]  bitn;
      logic [11:0] moff;
      logic [8:0]  mlen;
      logic [63:0] grp;
      logic [2:0]  phase;
      logic        stopped;
      logic [1:0]  status;
   } ps_type;

   localparam logic [1:0] F_IDLE   = 2'd0;
   localparam logic [1:0] F_REPLAY = 2'd1;
   localparam logic [1:0] F_LAST   = 2'd2;
   localparam logic [1:0] F_PUSH   = 2'd3;

   function automatic logic [23:0] room(input logic [23:0] wr, input logic [23:0] cap);
      room = (wr >= cap) ? 24'd0 : cap - wr;
   endfunction

   function automatic logic [31:0] consume(input logic [31:0] rem, input logic [8:0] n);
      consume = (rem > {23'd0, n}) ? rem - {23'd0, n} : 32'd0;
   endfunction

   function automatic ps_type settle(input ps_type s, input logic [23:0] cap);
      ps_type r;
      r = s;
      if (s.rem == 32'd0) begin
         r.stopped = 1'b1;
         r.status  = ST_COUNT;
      end else if (s.bitn >= 4'd8) begin
         r.phase = PH_TAG;
      end else if (s.tag[s.bitn[2:0]]) begin
         if (room(s.wr, cap) == 24'd0) begin
            r.stopped = 1'b1;
            r.status  = ST_CAPACITY;
         end else begin
            r.phase = PH_LIT;
         end
      end else begin
         r.phase = PH_MA;
      end
      return r;
   endfunction

   function automatic ps_type run_match(input ps_type s, input logic [23:0] cap,
                                        output logic ov, output op_type op);
      ps_type r;
      r  = s;
      ov = 1'b0;
      op = '0;
      if (room(s.wr, cap) < {15'd0, s.mlen}) begin
         r.stopped = 1'b1;
         r.status  = ST_CAPACITY;
      end else begin
         ov      = 1'b1;
         op.kind = OP_MATCH;
         op.val  = s.moff;
         op.len  = s.mlen;
         r.wr    = s.wr + {15'd0, s.mlen};
         r.rem   = consume(s.rem, s.mlen);
         r.bitn  = s.bitn + 4'd1;
         r       = settle(r, cap);
      end
      return r;
   endfunction

   function automatic ps_type parse(input ps_type s, input logic [7:0] b, input logic ext,
                                    input logic [23:0] cap, output logic ov,
                                    output op_type op);
      ps_type r;
      r  = s;
      ov = 1'b0;
      op = '0;
      case (s.phase)
         PH_TAG: begin
            r.tag  = b;
            r.bitn = 4'd0;
            if (b == GROUP_TAG && s.rem > 32'd8) begin
               if (room(s.wr, cap) < 24'd8) begin
                  r.stopped = 1'b1;
                  r.status  = ST_CAPACITY;
               end else begin
                  r.grp   = '0;
                  r.phase = PH_GROUP;
               end
            end else begin
               r = settle(r, cap);
            end
         end
         PH_GROUP: begin
            r.grp[s.bitn[2:0]*8 +: 8] = b;
            r.bitn = s.bitn + 4'd1;
            if (r.bitn >= 4'd8) begin
               if (room(s.wr, cap) < 24'd8) begin
                  r.stopped = 1'b1;
                  r.status  = ST_CAPACITY;
               end else begin
                  ov      = 1'b1;
                  op.kind = OP_GROUP;
                  r.wr    = s.wr + 24'd8;
                  r.rem   = consume(s.rem, 9'd8);
                  if (r.rem == 32'd0) begin
                     r.stopped = 1'b1;
                     r.status  = ST_COUNT;
                  end else begin
                     r.phase = PH_TAG;
                  end
               end
            end
         end
         PH_LIT: begin
            if (room(s.wr, cap) == 24'd0) begin
               r.stopped = 1'b1;
               r.status  = ST_CAPACITY;
            end else begin
               ov      = 1'b1;
               op.kind = OP_LIT;
               op.val  = {4'd0, b};
               r.wr    = s.wr + 24'd1;
               r.rem   = consume(s.rem, 9'd1);
               r.bitn  = s.bitn + 4'd1;
               r       = settle(r, cap);
            end
         end
         PH_MA: begin
            r.moff  = {4'd0, b};
            r.phase = PH_MB;
         end
         PH_MB: begin
            r.moff = s.moff | {b[7:4], 8'd0};
            r.mlen = {5'd0, b[3:0]} + 9'd3;
            if (ext && r.mlen == 9'd18) begin
               r.phase = PH_MC;
            end else begin
               r = run_match(r, cap, ov, op);
            end
         end
         PH_MC: begin
            r.mlen = {1'b0, b} + 9'd18;
            r = run_match(r, cap, ov, op);
         end
         default: begin
            r.phase = PH_TAG;
         end
      endcase
      return r;
   endfunction

   logic [1:0]           fst_ff, fst_in;
   ps_type               st_ff, st_in;
   logic [31:0]          hbuf_ff, hbuf_in;
   logic [3:0]           hph_ff, hph_in;
   logic                 ext_ff, ext_in;
   logic                 last_ff, last_in;
   logic                 skip_ff, skip_in;
   logic [1:0]           rix_ff, rix_in;
   op_type [MAX_OPS-1:0] ops_ff, ops_in;
   logic [2:0]           nops_ff, nops_in;
   logic                 sets_ff, sets_in;
   logic [11:0]          start_ff, start_in;

   ps_type     s;
   logic       ov;
   op_type     op;
   logic [2:0] ph;

   always_comb begin
      fst_in     = fst_ff;
      hbuf_in    = hbuf_ff;
      hph_in     = hph_ff;
      ext_in     = ext_ff;
      last_in    = last_ff;
      skip_in    = skip_ff;
      rix_in     = rix_ff;
      ops_in     = ops_ff;
      nops_in    = nops_ff;
      sets_in    = sets_ff;
      start_in   = start_ff;
      s          = st_ff;
      ov         = 1'b0;
      op         = '0;
      ph         = hph_ff[2:0];
      req_ready  = (fst_ff == F_IDLE);
      push_valid = 1'b0;

      case (fst_ff)
         F_IDLE: begin
            if (req_valid) begin
               last_in = req_data.in_last;
               if (st_ff.stopped) begin
                  // Bytes after a stop are dropped until the stream's last byte.
                  skip_in = 1'b1;
                  nops_in = 3'd0;
                  sets_in = 1'b0;
                  if (req_data.in_last) begin
                     fst_in = F_PUSH;
                  end
               end else begin
                  skip_in = 1'b0;
                  nops_in = 3'd0;
                  sets_in = 1'b0;
                  fst_in  = F_LAST;
                  if (st_ff.phase == PH_HEADER) begin
                     if (!ph[2]) begin
                        s.rem[ph[1:0]*8 +: 8] = req_data.in_byte;
                     end else begin
                        hbuf_in[ph[1:0]*8 +: 8] = req_data.in_byte;
                     end
                     hph_in = {1'b0, ph} + 4'd1;
                     if (hph_in < 4'd8) begin
                        if (req_data.in_last) begin
                           s.stopped = 1'b1;
                           s.status  = ST_ENDED;
                        end
                     end else if (hbuf_in == MAGIC_WORD) begin
                        ext_in   = 1'b1;
                        sets_in  = 1'b1;
                        start_in = START_EXT;
                        if (s.rem == 32'd0) begin
                           s.stopped = 1'b1;
                           s.status  = ST_COUNT;
                        end else begin
                           s.phase = PH_TAG;
                        end
                     end else begin
                        ext_in   = 1'b0;
                        sets_in  = 1'b1;
                        start_in = START_PLAIN;
                        if (s.rem == 32'd0) begin
                           s.stopped = 1'b1;
                           s.status  = ST_COUNT;
                        end else begin
                           // The four bytes compared with the magic word are parsed again as data.
                           s.phase = PH_TAG;
                           rix_in  = 2'd0;
                           fst_in  = F_REPLAY;
                        end
                     end
                  end else begin
                     s = parse(st_ff, req_data.in_byte, ext_ff, csr_cap, ov, op);
                  end
               end
            end
         end
         F_REPLAY: begin
            if (!st_ff.stopped) begin
               s = parse(st_ff, hbuf_ff[rix_ff*8 +: 8], ext_ff, csr_cap, ov, op);
            end
            rix_in = rix_ff + 2'd1;
            if (rix_ff == 2'd3) begin
               fst_in = F_LAST;
            end
         end
         F_LAST: begin
            if (!st_ff.stopped && last_ff) begin
               // A match missing its length byte runs with that byte read as zero.
               if (st_ff.phase == PH_MB) begin
                  s.mlen = 9'd3;
                  s = run_match(s, csr_cap, ov, op);
               end else if (st_ff.phase == PH_MC) begin
                  s.mlen = 9'd18;
                  s = run_match(s, csr_cap, ov, op);
               end
               if (!s.stopped) begin
                  s.stopped = 1'b1;
                  s.status  = ST_ENDED;
               end
            end
            // The window start must reach the engine even when no bytes follow.
            if (ov || nops_ff != 3'd0 || s.stopped || last_ff || sets_ff) begin
               fst_in = F_PUSH;
            end else begin
               fst_in = F_IDLE;
            end
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               fst_in  = F_IDLE;
               nops_in = 3'd0;
               if (last_ff) begin
                  s       = '0;
                  hbuf_in = '0;
                  hph_in  = '0;
                  ext_in  = 1'b0;
                  skip_in = 1'b0;
               end
            end
         end
         default: begin
            fst_in = F_IDLE;
         end
      endcase

      if (ov) begin
         ops_in[nops_in[1:0]] = op;
         nops_in = nops_in + 3'd1;
      end
      st_in = s;
   end

   always_comb begin
      push_data           = '0;
      push_data.ops       = ops_ff;
      push_data.nops      = nops_ff;
      push_data.grp       = st_ff.grp;
      push_data.status    = st_ff.status;
      push_data.stop      = st_ff.stopped && !skip_ff;
      push_data.last      = last_ff;
      push_data.set_start = sets_ff;
      push_data.start     = start_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fst_ff   <= F_IDLE;
         st_ff    <= '0;
         hbuf_ff  <= '0;
         hph_ff   <= '0;
         ext_ff   <= 1'b0;
         last_ff  <= 1'b0;
         skip_ff  <= 1'b0;
         rix_ff   <= '0;
         nops_ff  <= '0;
         sets_ff  <= 1'b0;
      end else begin
         fst_ff   <= fst_in;
         st_ff    <= st_in;
         hbuf_ff  <= hbuf_in;
         hph_ff   <= hph_in;
         ext_ff   <= ext_in;
         last_ff  <= last_in;
         skip_ff  <= skip_in;
         rix_ff   <= rix_in;
         nops_ff  <= nops_in;
         sets_ff  <= sets_in;
      end
      ops_ff   <= ops_in;
      start_ff <= start_in;
   end

endmodule

// ===== src/lzwd_queue.sv =====
// Two-entry queue of step records between the front parser and the copy engine.
// Uses lzwd_pkg.
module lzwd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  lzwd_pkg::step_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output lzwd_pkg::step_type pop_data
);
   import lzwd_pkg::*;

   step_type   mem_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = mem_ff[rp_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

endmodule

// ===== src/lzwd_back.sv =====
// Copy engine: carries out step records against the history window and packs
// the produced bytes into result words. Uses lzwd_pkg and lzwd_ram.
module lzwd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  lzwd_pkg::step_type pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lzwd_pkg::rsp_type  rsp_data
);
   import lzwd_pkg::*;

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_OP   = 3'd1;
   localparam logic [2:0] B_LIT  = 3'd2;
   localparam logic [2:0] B_GRP  = 3'd3;
   localparam logic [2:0] B_MRD  = 3'd4;
   localparam logic [2:0] B_MWR  = 3'd5;
   localparam logic [2:0] B_END  = 3'd6;

   localparam logic [WIN_AW:0] FILL_FULL = WIN_DEPTH[WIN_AW:0];

   logic [2:0]        bst_ff, bst_in;
   step_type          rec_ff, rec_in;
   logic [2:0]        oix_ff, oix_in;
   logic [8:0]        cnt_ff, cnt_in;
   logic [WIN_AW-1:0] wpos_ff, wpos_in;
   logic [WIN_AW-1:0] start_ff, start_in;
   logic [WIN_AW:0]   fill_ff, fill_in;
   logic              hit_ff, hit_in;
   logic [63:0]       pack_ff, pack_in;
   logic [3:0]        pcnt_ff, pcnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   op_type            cur;
   logic              put_req, can_put, put_done, out_free;
   logic [7:0]        put_val;
   logic              re;
   logic [WIN_AW-1:0] raddr;
   logic [7:0]        rdata;

   lzwd_ram #(.WIDTH(8), .DEPTH(WIN_DEPTH)) u_window (
      .clock(clock),
      .we   (put_done),
      .waddr(wpos_ff),
      .wdata(put_val),
      .re   (re),
      .raddr(raddr),
      .rdata(rdata)
   );

   assign cur       = rec_ff.ops[oix_ff[1:0]];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign can_put   = (pcnt_ff != 4'd8) || out_free;
   assign put_done  = put_req && can_put;
   assign raddr     = cur.val + {3'd0, cnt_ff};
   assign pop_ready = (bst_ff == B_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      bst_in       = bst_ff;
      rec_in       = rec_ff;
      oix_in       = oix_ff;
      cnt_in       = cnt_ff;
      wpos_in      = wpos_ff;
      start_in     = start_ff;
      fill_in      = fill_ff;
      hit_in       = hit_ff;
      pack_in      = pack_ff;
      pcnt_in      = pcnt_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      put_req      = 1'b0;
      put_val      = '0;
      re           = 1'b0;

      case (bst_ff)
         B_IDLE: begin
            if (pop_valid) begin
               rec_in = pop_data;
               oix_in = 3'd0;
               bst_in = B_OP;
               if (pop_data.set_start) begin
                  wpos_in  = pop_data.start;
                  start_in = pop_data.start;
               end
            end
         end
         B_OP: begin
            cnt_in = 9'd0;
            if (oix_ff == rec_ff.nops) begin
               bst_in = B_END;
            end else begin
               case (cur.kind)
                  OP_LIT:   bst_in = B_LIT;
                  OP_GROUP: bst_in = B_GRP;
                  OP_MATCH: bst_in = B_MRD;
                  default:  oix_in = oix_ff + 3'd1;
               endcase
            end
         end
         B_LIT: begin
            put_req = 1'b1;
            put_val = cur.val[7:0];
            if (can_put) begin
               oix_in = oix_ff + 3'd1;
               bst_in = B_OP;
            end
         end
         B_GRP: begin
            put_req = 1'b1;
            put_val = rec_ff.grp[cnt_ff[2:0]*8 +: 8];
            if (can_put) begin
               cnt_in = cnt_ff + 9'd1;
               if (cnt_ff == 9'd7) begin
                  oix_in = oix_ff + 3'd1;
                  bst_in = B_OP;
               end
            end
         end
         B_MRD: begin
            // Window bytes not yet written in this stream read as the fill byte.
            re     = 1'b1;
            hit_in = {1'b0, raddr - start_ff} < fill_ff;
            bst_in = B_MWR;
         end
         B_MWR: begin
            put_req = 1'b1;
            put_val = hit_ff ? rdata : FILL_BYTE;
            if (can_put) begin
               cnt_in = cnt_ff + 9'd1;
               if (cnt_ff + 9'd1 == cur.len) begin
                  oix_in = oix_ff + 3'd1;
                  bst_in = B_OP;
               end else begin
                  bst_in = B_MRD;
               end
            end
         end
         B_END: begin
            if (pcnt_ff != 4'd0 || rec_ff.stop) begin
               if (out_free) begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.out_data      = pack_ff;
                  rsp_in.out_count     = pcnt_ff;
                  rsp_in.out_last      = 1'b1;
                  rsp_in.run_status    = rec_ff.status;
                  pack_in              = '0;
                  pcnt_in              = 4'd0;
                  bst_in               = B_IDLE;
                  if (rec_ff.last) begin
                     fill_in = '0;
                  end
               end
            end else begin
               bst_in = B_IDLE;
               if (rec_ff.last) begin
                  fill_in = '0;
               end
            end
         end
         default: begin
            bst_in = B_IDLE;
         end
      endcase

      if (put_done) begin
         wpos_in = wpos_ff + 1'b1;
         if (fill_ff != FILL_FULL) begin
            fill_in = fill_ff + 1'b1;
         end
         if (pcnt_ff == 4'd8) begin
            // A full word leaves once another byte of the step shows up, or at the step's end.
            rsp_valid_in      = 1'b1;
            rsp_in.out_data   = pack_ff;
            rsp_in.out_count  = pcnt_ff;
            rsp_in.out_last   = 1'b0;
            rsp_in.run_status = rec_ff.status;
            pack_in           = {56'd0, put_val};
            pcnt_in           = 4'd1;
         end else begin
            pack_in[pcnt_ff[2:0]*8 +: 8] = put_val;
            pcnt_in = pcnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bst_ff       <= B_IDLE;
         oix_ff       <= '0;
         cnt_ff       <= '0;
         wpos_ff      <= '0;
         start_ff     <= '0;
         fill_ff      <= '0;
         pack_ff      <= '0;
         pcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bst_ff       <= bst_in;
         oix_ff       <= oix_in;
         cnt_ff       <= cnt_in;
         wpos_ff      <= wpos_in;
         start_ff     <= start_in;
         fill_ff      <= fill_in;
         pack_ff      <= pack_in;
         pcnt_ff      <= pcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rec_ff <= rec_in;
      hit_ff <= hit_in;
      rsp_ff <= rsp_in;
   end

endmodule

// ===== src/lzss_window_decoder.sv =====
// LZSS decoder with a 4096-byte window. The parser takes a live byte through an idle
// and a last state, plus a push state when the byte hands a step to the engine; the
// header replay adds a replay state. The engine takes a step through idle, op and end
// states; a literal adds one put, a group one put per byte and each copied match byte
// a window RAM read, then a write, so a long match sets the rate. A two-entry step queue
// lets parser and engine run on different items at once.
// Reset is synchronous; window contents are tracked by a fill count, no clearing pass.
module lzss_window_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzwd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lzwd_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [23:0]       csr_write_data
);
   import lzwd_pkg::*;

   logic [23:0] cap_ff, cap_in;
   logic        push_valid, push_ready, pop_valid, pop_ready;
   step_type    push_data, pop_data;

   assign cap_in = csr_write_en ? csr_write_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
      end else begin
         cap_ff <= cap_in;
      end
   end

   lzwd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_cap   (cap_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   lzwd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   lzwd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data (pop_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule
